### rtl/core/fqsc_pkg.sv
// Shared types, constants and delay tables for the fault qualifier.
`default_nettype none
package fqsc_pkg;

    localparam int NUM_FAULTS  = 51;
    localparam int RECORD_BASE = 32;
    localparam int NUM_LANES   = 4;
    localparam int LANE_W      = $clog2(NUM_LANES);
    localparam int SLOTS       = (NUM_FAULTS + NUM_LANES - 1) / NUM_LANES;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int IDX_W       = SLOT_W + LANE_W;
    localparam int ROM_LEN     = 51;
    localparam int CONF_W      = 9;
    localparam int CLR_W       = 15;
    localparam int REC_W       = 19;
    localparam int REC_IDX_W   = $clog2(REC_W);
    localparam int CNT_W       = 16;
    localparam int S_DATA_W    = ((NUM_FAULTS + 7) / 8) * 8;
    localparam int M_FIELD_W   = NUM_FAULTS + REC_W + CNT_W + 1;
    localparam int M_DATA_W    = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [CONF_W-1:0] CONFIRM_ROM [ROM_LEN] = '{
        9'd300, 9'd300, 9'd300, 9'd0,   9'd500, 9'd500, 9'd200, 9'd200,
        9'd200, 9'd200, 9'd200, 9'd200, 9'd500, 9'd500, 9'd500, 9'd500,
        9'd500, 9'd500, 9'd500, 9'd500, 9'd300, 9'd300, 9'd300, 9'd0,
        9'd0,   9'd300, 9'd300, 9'd200, 9'd200, 9'd200, 9'd200, 9'd200,
        9'd500, 9'd500, 9'd500, 9'd200, 9'd200, 9'd200, 9'd200, 9'd20,
        9'd20,  9'd500, 9'd500, 9'd500, 9'd500, 9'd80,  9'd80,  9'd500,
        9'd20,  9'd300, 9'd300
    };

    localparam logic [CLR_W-1:0] CLEAR_ROM [ROM_LEN] = '{
        15'd0,     15'd0,     15'd0,     15'd0,     15'd100,   15'd100,   15'd50,
        15'd50,    15'd50,    15'd50,    15'd50,    15'd50,    15'd100,   15'd100,
        15'd20,    15'd20,    15'd20,    15'd20,    15'd20,    15'd20,    15'd20,
        15'd0,     15'd0,     15'd0,     15'd0,     15'd600,   15'd600,   15'd0,
        15'd0,     15'd0,     15'd0,     15'd20,    15'd18000, 15'd18000, 15'd20,
        15'd18000, 15'd18000, 15'd18000, 15'd18000, 15'd18000, 15'd18000, 15'd100,
        15'd100,   15'd100,   15'd100,   15'd18000, 15'd18000, 15'd18000, 15'd18000,
        15'd20,    15'd20
    };

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             latched;
        logic             hit;
    } lane_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } seq_state_t;

    function automatic logic [CONF_W-1:0] confirm_limit(input logic [IDX_W-1:0] idx);
        confirm_limit = '0;
        if (idx < IDX_W'(ROM_LEN)) begin
            confirm_limit = CONFIRM_ROM[idx];
        end
    endfunction

    function automatic logic [CLR_W-1:0] clear_limit(input logic [IDX_W-1:0] idx);
        clear_limit = '0;
        if (idx < IDX_W'(ROM_LEN)) begin
            clear_limit = CLEAR_ROM[idx];
        end
    endfunction

endpackage
`default_nettype wire

### rtl/core/fault_qualifier_set_clear_delay.sv
// A result reaches m_tvalid through the lane walk, the merge register and the
// output register. A tick walks an accept state, 13 lane slots (51 faults over
// 4 lanes), a lane-to-merge drain state and an output load state, one at a time.
// The next tick is accepted while a finished result waits in the output register.
// Reset (aresetn low, synchronous) clears all counters, latched bits and records.
`default_nettype none
module fault_qualifier_set_clear_delay
    import fqsc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // raw_faults[50:0], zero pad
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata   // latched_faults, record_flags,
                                               // record_count, system_fault, pad
);

    seq_state_t            state_reg, state_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [NUM_FAULTS-1:0] raw_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]   m_tdata_reg;
    logic                  load_out;
    logic                  step;

    lane_res_t [NUM_LANES-1:0] lane_res;
    logic [NUM_FAULTS-1:0]     latched_faults;
    logic [REC_W-1:0]          record_flags;
    logic [CNT_W-1:0]          record_count;
    logic                      system_fault;

    assign s_tready = (state_reg == ST_IDLE);
    assign step     = (state_reg == ST_RUN);

    always_comb begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                slot_next = '0;
                if (s_tvalid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                slot_next = slot_reg + 1'b1;
                if (slot_reg == SLOT_W'(SLOTS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            slot_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            raw_reg <= s_tdata[NUM_FAULTS-1:0];
        end
        if (load_out) begin
            m_tdata_reg <= M_DATA_W'({system_fault, record_count, record_flags,
                                      latched_faults});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        fqsc_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .lane_id (LANE_W'(l)),
            .step    (step),
            .slot    (slot_reg),
            .raw     (raw_reg),
            .res     (lane_res[l])
        );
    end

    fqsc_merge u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .lane_res       (lane_res),
        .latched_faults (latched_faults),
        .record_flags   (record_flags),
        .record_count   (record_count),
        .system_fault   (system_fault)
    );

`ifndef SYNTHESIS
    a_accept_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_RUN && slot_reg == '0))
        else $error("transfer did not start lane walk at slot zero");

    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (slot_reg < SLOT_W'(SLOTS)))
        else $error("lane slot beyond range");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_tvalid)
        else $error("result load did not raise m_tvalid");

    a_idle_no_lane_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !(lane_res[0].valid || lane_res[NUM_LANES-1].valid))
        else $error("lane result while idle");
`endif

endmodule
`default_nettype wire

### rtl/core/fqsc_lane.sv
// One qualifier lane: confirm and clear counters for every NUM_LANES-th fault.
`default_nettype none
module fqsc_lane
    import fqsc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [LANE_W-1:0]     lane_id,
    input  wire logic                  step,
    input  wire logic [SLOT_W-1:0]     slot,
    input  wire logic [NUM_FAULTS-1:0] raw,
    output lane_res_t                  res
);

    logic [CONF_W-1:0] conf_reg [SLOTS];
    logic [CLR_W-1:0]  clr_reg  [SLOTS];
    logic [SLOTS-1:0]  lat_reg;
    lane_res_t         res_reg;

    logic [IDX_W-1:0]  idx;
    logic              active;
    logic              raw_bit;
    logic [CONF_W-1:0] conf_cur, conf_next;
    logic [CLR_W-1:0]  clr_cur, clr_next;
    logic              lat_cur, lat_next;
    logic              hit;

    assign idx      = {slot, lane_id};
    assign active   = step && (idx < IDX_W'(NUM_FAULTS));
    assign conf_cur = conf_reg[slot];
    assign clr_cur  = clr_reg[slot];
    assign lat_cur  = lat_reg[slot];

    always_comb begin
        raw_bit   = 1'b0;
        conf_next = conf_cur;
        clr_next  = clr_cur;
        lat_next  = lat_cur;
        hit       = 1'b0;
        if (active) begin
            raw_bit = raw[idx];
        end
        if (raw_bit) begin
            clr_next = clear_limit(idx);
            if (!lat_cur) begin
                if (conf_cur < confirm_limit(idx)) begin
                    conf_next = conf_cur + 1'b1;
                end else begin
                    lat_next = 1'b1;
                    hit      = 1'b1;
                end
            end
        end else begin
            conf_next = '0;
            if (lat_cur) begin
                if (clr_cur != '0) begin
                    clr_next = clr_cur - 1'b1;
                end else begin
                    lat_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < SLOTS; s++) begin
                conf_reg[s] <= '0;
                clr_reg[s]  <= '0;
            end
            lat_reg <= '0;
            res_reg <= '0;
        end else begin
            if (active) begin
                conf_reg[slot] <= conf_next;
                clr_reg[slot]  <= clr_next;
                lat_reg[slot]  <= lat_next;
            end
            res_reg.valid   <= active;
            res_reg.idx     <= idx;
            res_reg.latched <= lat_next;
            res_reg.hit     <= active && hit;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

### rtl/core/fqsc_merge.sv
// Merge stage: collect lane results into the latched vector and event records.
`default_nettype none
module fqsc_merge
    import fqsc_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  lane_res_t [NUM_LANES-1:0]       lane_res,
    output logic      [NUM_FAULTS-1:0]      latched_faults,
    output logic      [REC_W-1:0]           record_flags,
    output logic      [CNT_W-1:0]           record_count,
    output logic                            system_fault
);

    localparam logic [NUM_FAULTS-1:0] SYS_MASK = {NUM_FAULTS{1'b1}} << RECORD_BASE;

    logic [NUM_FAULTS-1:0] latched_reg, latched_next;
    logic [REC_W-1:0]      sticky_reg, sticky_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    always_comb begin
        logic [IDX_W-1:0] k;
        latched_next = latched_reg;
        sticky_next  = sticky_reg;
        count_next   = count_reg;
        k            = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            if (lane_res[l].valid) begin
                latched_next[lane_res[l].idx] = lane_res[l].latched;
                if (lane_res[l].hit && (lane_res[l].idx >= IDX_W'(RECORD_BASE))) begin
                    count_next = count_next + 1'b1;
                    k          = lane_res[l].idx - IDX_W'(RECORD_BASE);
                    if (k < IDX_W'(REC_W)) begin
                        sticky_next[k[REC_IDX_W-1:0]] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latched_reg <= '0;
            sticky_reg  <= '0;
            count_reg   <= '0;
        end else begin
            latched_reg <= latched_next;
            sticky_reg  <= sticky_next;
            count_reg   <= count_next;
        end
    end

    assign latched_faults = latched_reg;
    assign record_flags   = sticky_reg;
    assign record_count   = count_reg;
    assign system_fault   = |(latched_reg & SYS_MASK);

endmodule
`default_nettype wire
